[sv/keyed_slot_queue_macros.svh]
// Assertion helpers for the keyed slot queue.
`ifndef KEYED_SLOT_QUEUE_MACROS_SVH
`define KEYED_SLOT_QUEUE_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define KSQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define KSQ_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define KSQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[sv/ksq_pkg.sv]
package ksq_pkg;

  localparam int CMD_W        = 2;
  localparam int FRAME_W      = 10;
  localparam int SUBFRAME_W   = 4;
  localparam int PAYLOAD_W    = 64;
  localparam int START_W      = 4;
  localparam int SLOT_INDEX_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 2'd0,
    CMD_FIND      = 2'd1,
    CMD_FIND_NEXT = 2'd2,
    CMD_DELETE    = 2'd3
  } cmd_t;

  // One stored slot: key and opaque packet content.
  typedef struct packed {
    logic [FRAME_W-1:0]    frame;
    logic [SUBFRAME_W-1:0] subframe;
    logic [PAYLOAD_W-1:0]  payload;
  } entry_t;

endpackage

[sv/ksq_ram.sv]
module ksq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/keyed_slot_queue.sv]
// Keyed slot queue: slot table of packets keyed by (frame, subframe).
// Add walks taken slots to the first free one; find and find next scan slots below used_length;
// delete scans below used_length, then trims trailing free slots from the used length.
// One transaction at a time; the next command can be taken in the cycle after the result registers.
// Reset (rst, synchronous): all slots free, used length zero, no result pending.
module keyed_slot_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Command channel
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  logic [ksq_pkg::CMD_W-1:0]           cmd,
  input  logic [ksq_pkg::FRAME_W-1:0]         frame_number,
  input  logic [ksq_pkg::SUBFRAME_W-1:0]      subframe_number,
  input  logic [ksq_pkg::PAYLOAD_W-1:0]       packet_payload,
  input  logic [ksq_pkg::START_W-1:0]         start_index,
  // Result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                accepted,
  output logic                                found,
  output logic [ksq_pkg::SLOT_INDEX_W-1:0]    slot_index,
  output logic [ksq_pkg::PAYLOAD_W-1:0]       found_payload
);

`include "keyed_slot_queue_macros.svh"

  // Slot address width, used-length width (holds QUEUE_DEPTH itself), and
  // common widths for comparing against the fixed-width ports.
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > ksq_pkg::START_W) ? CNT_W : ksq_pkg::START_W;
  localparam int SI_W  = (IDX_W > ksq_pkg::SLOT_INDEX_W) ? IDX_W : ksq_pkg::SLOT_INDEX_W;
  localparam int ENTRY_W = $bits(ksq_pkg::entry_t);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,  // wait for a command
    ST_ADD  = 6'b000010,  // walk taken flags for the first free slot
    ST_KEY  = 6'b000100,  // latch the key of the find-next start slot
    ST_SCAN = 6'b001000,  // stream slots through the key comparator
    ST_TRIM = 6'b010000,  // shrink used length past trailing free slots
    ST_DONE = 6'b100000   // hand the result to the output register
  } state_t;

  state_t               state;
  ksq_pkg::cmd_t        op;
  logic [QUEUE_DEPTH-1:0] slot_taken;
  logic [CNT_W-1:0]     used_length;
  logic [CNT_W-1:0]     ptr;
  logic                 cmp_valid;
  logic [IDX_W-1:0]     cmp_idx;
  logic [ksq_pkg::FRAME_W-1:0]    key_frame;
  logic [ksq_pkg::SUBFRAME_W-1:0] key_subframe;
  logic [ksq_pkg::PAYLOAD_W-1:0]  add_payload;

  // Staged result, moved to the output register from ST_DONE.
  logic                              res_accepted;
  logic                              res_found;
  logic [ksq_pkg::SLOT_INDEX_W-1:0]  res_index;
  logic [ksq_pkg::PAYLOAD_W-1:0]     res_payload;

  // Slot RAM signals
  logic                 ram_wr_en;
  logic [IDX_W-1:0]     ram_wr_addr;
  ksq_pkg::entry_t      ram_wr_data;
  logic                 ram_rd_en;
  logic [IDX_W-1:0]     ram_rd_addr;
  ksq_pkg::entry_t      ram_rd_data;

  logic                 cmd_fire;
  logic                 start_ok;
  logic [IDX_W-1:0]     ptr_idx;
  logic [IDX_W-1:0]     start_idx;
  logic [CNT_W-1:0]     start_after;
  logic                 add_stop;
  logic                 add_ok;
  logic                 issue;
  logic                 hit;
  logic [IDX_W-1:0]     trim_idx;
  logic [SI_W-1:0]      add_index_ext;
  logic [SI_W-1:0]      hit_index_ext;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;

  always_comb begin
    ptr_idx     = ptr[IDX_W-1:0];
    start_idx   = IDX_W'(start_index);
    start_ok    = CMP_W'(start_index) < CMP_W'(used_length);
    start_after = CNT_W'(CMP_W'(start_index) + CMP_W'(1));
    // Add stops at the used length or at the first free slot below it.
    add_stop    = (ptr == used_length) || !slot_taken[ptr_idx];
    add_ok      = ptr < CNT_W'(QUEUE_DEPTH);
    issue       = ptr < used_length;
    hit         = cmp_valid && slot_taken[cmp_idx] &&
                  (ram_rd_data.frame == key_frame) &&
                  (ram_rd_data.subframe == key_subframe);
    trim_idx    = IDX_W'(used_length - CNT_W'(1));
    add_index_ext = SI_W'(ptr_idx);
    hit_index_ext = SI_W'(cmp_idx);

    ram_wr_en            = (state == ST_ADD) && add_stop && add_ok;
    ram_wr_addr          = ptr_idx;
    ram_wr_data.frame    = key_frame;
    ram_wr_data.subframe = key_subframe;
    ram_wr_data.payload  = add_payload;

    // Read port: start-slot key for find next, else the scan pointer.
    if (state == ST_IDLE) begin
      ram_rd_en   = cmd_fire && (cmd == ksq_pkg::CMD_FIND_NEXT) && start_ok;
      ram_rd_addr = start_idx;
    end else begin
      ram_rd_en   = (state == ST_SCAN) && issue;
      ram_rd_addr = ptr_idx;
    end
  end

  ksq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer and table control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_taken   <= '0;
      used_length  <= '0;
      cmp_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Drop the output once the downstream side takes it, unless a new
      // result is loaded in the same cycle.
      if (result_valid && result_ready && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            op        <= ksq_pkg::cmd_t'(cmd);
            cmp_valid <= 1'b0;
            priority case (ksq_pkg::cmd_t'(cmd))
              ksq_pkg::CMD_ADD: begin
                ptr   <= '0;
                state <= ST_ADD;
              end
              ksq_pkg::CMD_FIND_NEXT: begin
                // Out-of-range start answers not-found at once.
                ptr   <= start_after;
                state <= start_ok ? ST_KEY : ST_DONE;
              end
              default: begin
                ptr   <= '0;
                state <= ST_SCAN;
              end
            endcase
          end
        end

        ST_ADD: begin
          if (add_stop) begin
            if (add_ok) begin
              slot_taken[ptr_idx] <= 1'b1;
              if (ptr == used_length) begin
                used_length <= used_length + CNT_W'(1);
              end
            end
            state <= ST_DONE;
          end else begin
            ptr <= ptr + CNT_W'(1);
          end
        end

        ST_KEY: begin
          state <= ST_SCAN;
        end

        ST_SCAN: begin
          // One slot enters the comparator per cycle, in the cycle after its read.
          if (issue) begin
            ptr <= ptr + CNT_W'(1);
          end
          cmp_idx <= ptr_idx;
          if (hit && (op == ksq_pkg::CMD_DELETE)) begin
            slot_taken[cmp_idx] <= 1'b0;
          end
          if (hit && (op != ksq_pkg::CMD_DELETE)) begin
            cmp_valid <= 1'b0;
            state     <= ST_DONE;
          end else begin
            cmp_valid <= issue;
            if (!issue && !cmp_valid) begin
              state <= (op == ksq_pkg::CMD_DELETE) ? ST_TRIM : ST_DONE;
            end
          end
        end

        ST_TRIM: begin
          if ((used_length != '0) && !slot_taken[trim_idx]) begin
            used_length <= used_length - CNT_W'(1);
          end else begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          // Advance only when the output register is free.
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command fields and staged result; payload registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      key_frame    <= frame_number;
      key_subframe <= subframe_number;
      add_payload  <= packet_payload;
      res_accepted <= 1'b0;
      res_found    <= 1'b0;
      res_index    <= '0;
      res_payload  <= '0;
    end
    if (state == ST_ADD && ram_wr_en) begin
      res_accepted <= 1'b1;
      res_index    <= add_index_ext[ksq_pkg::SLOT_INDEX_W-1:0];
    end
    if (state == ST_KEY) begin
      // Hold the stored key of the start slot as the search key.
      key_frame    <= ram_rd_data.frame;
      key_subframe <= ram_rd_data.subframe;
    end
    if (state == ST_SCAN && hit && (op != ksq_pkg::CMD_DELETE)) begin
      res_found   <= 1'b1;
      res_index   <= hit_index_ext[ksq_pkg::SLOT_INDEX_W-1:0];
      res_payload <= ram_rd_data.payload;
    end
    if (state == ST_DONE && (!result_valid || result_ready)) begin
      accepted      <= res_accepted;
      found         <= res_found;
      slot_index    <= res_index;
      found_payload <= res_payload;
    end
  end

  // Assertions
  `KSQ_ASSERT_ALWAYS(a_used_in_range, used_length <= CNT_W'(QUEUE_DEPTH), "used length beyond depth")
  `KSQ_ASSERT_IMPL(a_trim_done, (state == ST_DONE) && (op == ksq_pkg::CMD_DELETE), (used_length == '0) || slot_taken[trim_idx], "delete left a free trailing slot")
  `KSQ_ASSERT_NEXT(a_busy_after_cmd, cmd_fire, !cmd_ready, "new transaction taken while busy")
  `KSQ_ASSERT_ALWAYS(a_add_or_find, !(result_valid && accepted && found), "result both accepted and found")

endmodule
